/* hdl/ttsp_pkg.sv */
// Shared types, widths, pipeline stage positions and constant tables for the
// thrust-vector to tilt-setpoint core. Depends on nothing.
`timescale 1ns / 1ps

package ttsp_pkg;

    localparam int FORCE_W       = 24;
    localparam int SPEED_W       = 24;
    localparam int TILT1_W       = 19;
    localparam int TILT2_W       = 17;
    localparam int ROT_W         = 2;

    localparam int CORDIC_STAGES = 31;
    localparam int SQRT_STEPS    = 32;
    localparam int RAD_W         = 2 * SQRT_STEPS;
    localparam int ROOT_W        = SQRT_STEPS;
    localparam int REM_W         = SQRT_STEPS + 2;
    localparam int CD_W          = 42;
    localparam int ACC_W         = 34;
    localparam int MAG_W         = ACC_W - 1;
    localparam int PROD_W        = MAG_W + 32;
    localparam int Q_W           = 21;
    localparam int STEP_W        = 5;

    // stage positions, counted in register layers from the input register
    localparam int P_SQ_IN  = 2;
    localparam int P_SQ_OUT = P_SQ_IN + SQRT_STEPS;
    localparam int P_C1_OUT = 1 + CORDIC_STAGES;
    localparam int P_C2_OUT = P_SQ_OUT + CORDIC_STAGES;
    localparam int POST_LAT = 3;
    localparam int P_T1     = P_C1_OUT + POST_LAT;
    localparam int P_T2     = P_C2_OUT + POST_LAT;
    localparam int P_N      = P_SQ_OUT + 1;
    localparam int LAT      = P_T2 + 1;

    localparam logic signed [ACC_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic [31:0]             TWO_OVER_PI = 32'hA2F9836E;
    localparam logic signed [Q_W-1:0]   T1_MAX      = 21'sd131072;
    localparam logic signed [Q_W-1:0]   T1_MIN      = -21'sd131072;
    localparam logic signed [Q_W-1:0]   T2_MAX      = 21'sd65535;
    localparam logic signed [Q_W-1:0]   T2_FLOOR    = -21'sd1966;

    // atan(2^-i) in radians, Q2.30, truncated
    localparam logic [29:0] ATAN_TAB [0:CORDIC_STAGES-1] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
        30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
        30'h00000001
    };

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic signed [CD_W-1:0]  x;
        logic signed [CD_W-1:0]  y;
        logic signed [ACC_W-1:0] acc;
    } cd_t;

    function automatic logic signed [ACC_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [29:0] v;
        v = (32'(idx) < CORDIC_STAGES) ? ATAN_TAB[idx] : 30'd0;
        return $signed({4'b0000, v});
    endfunction

endpackage

/* hdl/ttsp_sqrt_cell.sv */
// One restoring square-root cell: settles one root bit per cycle while en is high.
// Depends on ttsp_pkg.
`timescale 1ns / 1ps

module ttsp_sqrt_cell
(
    input  logic          clk,
    input  logic          en,
    input  ttsp_pkg::sq_t din,
    output ttsp_pkg::sq_t dout
);

    ttsp_pkg::sq_t             dout_reg;
    ttsp_pkg::sq_t             dout_next;
    logic [ttsp_pkg::REM_W-1:0] cur;
    logic [ttsp_pkg::REM_W-1:0] trial;

    always_comb
    begin
        // bring down the next two radicand bits, try the next root bit
        cur   = {din.rem[ttsp_pkg::REM_W-3:0], din.rad[ttsp_pkg::RAD_W-1 -: 2]};
        trial = {din.root, 2'b01};
        dout_next.rad = {din.rad[ttsp_pkg::RAD_W-3:0], 2'b00};
        if (cur >= trial)
        begin
            dout_next.rem  = cur - trial;
            dout_next.root = {din.root[ttsp_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            dout_next.rem  = cur;
            dout_next.root = {din.root[ttsp_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

/* hdl/ttsp_cordic_cell.sv */
// One vectoring CORDIC cell: one micro-rotation per cycle while en is high, step set by step_idx.
// Depends on ttsp_pkg.
`timescale 1ns / 1ps

module ttsp_cordic_cell
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [ttsp_pkg::STEP_W-1:0]   step_idx,
    input  ttsp_pkg::cd_t                 din,
    output ttsp_pkg::cd_t                 dout
);

    ttsp_pkg::cd_t                    dout_reg;
    ttsp_pkg::cd_t                    dout_next;
    logic signed [ttsp_pkg::CD_W-1:0]  dx;
    logic signed [ttsp_pkg::CD_W-1:0]  dy;
    logic signed [ttsp_pkg::ACC_W-1:0] ang;

    always_comb
    begin
        dx  = din.x >>> step_idx;
        dy  = din.y >>> step_idx;
        ang = ttsp_pkg::atan_entry(step_idx);
        // rotate towards the x axis
        if (din.y > 0)
        begin
            dout_next.x   = din.x + dy;
            dout_next.y   = din.y - dx;
            dout_next.acc = din.acc + ang;
        end
        else
        begin
            dout_next.x   = din.x - dy;
            dout_next.y   = din.y + dx;
            dout_next.acc = din.acc - ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

/* hdl/ttsp_angle_scale.sv */
// Converts a radian CORDIC angle (Q2.30) to quarter turns (Q2.16), rounding
// half away from zero, over three register stages. Depends on ttsp_pkg.
`timescale 1ns / 1ps

module ttsp_angle_scale
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [ttsp_pkg::ACC_W-1:0] acc,
    output logic signed [ttsp_pkg::Q_W-1:0]   angle
);

    logic                              neg_a_reg;
    logic [ttsp_pkg::MAG_W-1:0]        mag_reg;
    logic [ttsp_pkg::MAG_W-1:0]        mag_next;
    logic                              neg_b_reg;
    logic [ttsp_pkg::PROD_W-1:0]       prod_reg;
    logic [ttsp_pkg::PROD_W-1:0]       prod_next;
    logic [ttsp_pkg::PROD_W-1:0]       rnd;
    logic [ttsp_pkg::Q_W-2:0]          q;
    logic signed [ttsp_pkg::Q_W-1:0]   angle_reg;
    logic signed [ttsp_pkg::Q_W-1:0]   angle_next;
    logic signed [ttsp_pkg::ACC_W-1:0] abs_acc;

    always_comb
    begin
        abs_acc    = (acc < 0) ? -acc : acc;
        mag_next   = abs_acc[ttsp_pkg::MAG_W-1:0];
        prod_next  = ttsp_pkg::PROD_W'(mag_reg) * ttsp_pkg::PROD_W'(ttsp_pkg::TWO_OVER_PI);
        rnd        = prod_reg + (ttsp_pkg::PROD_W'(1) << 45);
        q          = rnd[46 +: ttsp_pkg::Q_W-1];
        angle_next = neg_b_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg <= (acc < 0);
            mag_reg   <= mag_next;
            neg_b_reg <= neg_a_reg;
            prod_reg  <= prod_next;
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

/* hdl/thrust_vector_to_tilt_setpoint_core.sv */
// Thrust-vector to tilt-setpoint core: rotor speed, first and second tilt.
// Throughput: one transfer per cycle; the whole chain advances together and
// holds only while a finished result waits at the output with tready low.
// Reset (rst_n, asynchronous, active low) clears the valid flags; no payload
// register is reset. Depends on ttsp_pkg, the cell modules and ttsp_angle_scale.
`timescale 1ns / 1ps

module thrust_vector_to_tilt_setpoint_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // force_x, force_y, force_z
    input  logic [1:0]  s_axis_tuser,   // rotor_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // rotor_speed, tilt_first, tilt_second, zero pad
    output logic [1:0]  m_axis_tuser    // rotor_out
);

    localparam int LAT = ttsp_pkg::LAT;

    logic en;

    // Valid flag for every stage; index LAT is the output register.
    logic v_reg [0:LAT];

    // Payload travelling with each item
    logic [ttsp_pkg::ROT_W-1:0]          rot_reg   [0:LAT];
    logic [ttsp_pkg::FORCE_W-1:0]        fxc_reg   [0:ttsp_pkg::P_SQ_OUT];
    logic                                z1_reg    [1:ttsp_pkg::P_C1_OUT];
    logic                                yzz_reg   [ttsp_pkg::P_SQ_IN:ttsp_pkg::P_T2];
    logic [ttsp_pkg::SPEED_W-1:0]        n_reg     [ttsp_pkg::P_N:ttsp_pkg::P_T2];
    logic signed [ttsp_pkg::Q_W-1:0]     t1_reg    [ttsp_pkg::P_T1+1:ttsp_pkg::P_T2];

    logic signed [ttsp_pkg::FORCE_W-1:0] fy0_reg;
    logic signed [ttsp_pkg::FORCE_W-1:0] fz0_reg;
    logic [47:0]                         fx2_reg;
    logic [47:0]                         fy2_reg;
    logic [47:0]                         fz2_reg;
    logic [47:0]                         yz_reg;
    logic [47:0]                         ss_reg;
    ttsp_pkg::cd_t                       c1_init_reg;

    logic [ttsp_pkg::SPEED_W-1:0]        speed_out_reg;
    logic signed [ttsp_pkg::TILT1_W-1:0] t1_out_reg;
    logic signed [ttsp_pkg::TILT2_W-1:0] t2_out_reg;

    // Combinational helpers
    logic signed [ttsp_pkg::FORCE_W-1:0] fx_in;
    logic [ttsp_pkg::FORCE_W-1:0]        fxc_next;
    logic signed [47:0]                  fy_sq;
    logic signed [47:0]                  fz_sq;
    logic signed [ttsp_pkg::CD_W-1:0]    c1_x0;
    logic signed [ttsp_pkg::CD_W-1:0]    c1_y0;
    ttsp_pkg::cd_t                       c1_init_next;
    logic [47:0]                         yz_next;
    logic [ttsp_pkg::REM_W-1:0]          root1_ext;
    logic [ttsp_pkg::SPEED_W:0]          n_round;
    logic [ttsp_pkg::SPEED_W-1:0]        n_next;
    logic signed [ttsp_pkg::ACC_W-1:0]   post1_acc;
    logic signed [ttsp_pkg::Q_W-1:0]     t1_q;
    logic signed [ttsp_pkg::Q_W-1:0]     t2_q;
    logic signed [ttsp_pkg::Q_W-1:0]     t1_sat;
    logic signed [ttsp_pkg::Q_W-1:0]     t2_sat;

    // Cell chains
    ttsp_pkg::sq_t sq1 [0:ttsp_pkg::SQRT_STEPS];
    ttsp_pkg::sq_t sq2 [0:ttsp_pkg::SQRT_STEPS];
    ttsp_pkg::cd_t c1  [0:ttsp_pkg::CORDIC_STAGES];
    ttsp_pkg::cd_t c2  [0:ttsp_pkg::CORDIC_STAGES];

    // The chain moves as one; hold everything while the output is stalled.
    assign en            = !v_reg[LAT] || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        fx_in    = $signed(s_axis_tdata[23:0]);
        // drop a negative x force to zero
        fxc_next = fx_in[ttsp_pkg::FORCE_W-1] ? '0 : fx_in;

        fy_sq = 48'(fy0_reg) * 48'(fy0_reg);
        fz_sq = 48'(fz0_reg) * 48'(fz0_reg);

        // first tilt vector: x = -fz * 256, y = fy * 256; turn by pi when x < 0
        c1_x0 = -(ttsp_pkg::CD_W'(fz0_reg) <<< 8);
        c1_y0 = ttsp_pkg::CD_W'(fy0_reg) <<< 8;
        if (c1_x0 < 0)
        begin
            c1_init_next.x   = -c1_x0;
            c1_init_next.y   = -c1_y0;
            c1_init_next.acc = (c1_y0 >= 0) ? ttsp_pkg::PI_Q30 : -ttsp_pkg::PI_Q30;
        end
        else
        begin
            c1_init_next.x   = c1_x0;
            c1_init_next.y   = c1_y0;
            c1_init_next.acc = '0;
        end

        yz_next = fy2_reg + fz2_reg;

        // round the norm to nearest, saturate to the field
        root1_ext = ttsp_pkg::REM_W'(sq1[ttsp_pkg::SQRT_STEPS].root);
        n_round   = (ttsp_pkg::SPEED_W+1)'(sq1[ttsp_pkg::SQRT_STEPS].root)
                  + ((sq1[ttsp_pkg::SQRT_STEPS].rem > root1_ext) ? 25'd1 : 25'd0);
        n_next    = n_round[ttsp_pkg::SPEED_W] ? '1 : n_round[ttsp_pkg::SPEED_W-1:0];

        // a null tilt vector gives a zero first tilt
        post1_acc = z1_reg[ttsp_pkg::P_C1_OUT] ? '0 : c1[ttsp_pkg::CORDIC_STAGES].acc;

        t1_sat = t1_reg[ttsp_pkg::P_T2];
        if (t1_sat > ttsp_pkg::T1_MAX)
            t1_sat = ttsp_pkg::T1_MAX;
        else if (t1_sat < ttsp_pkg::T1_MIN)
            t1_sat = ttsp_pkg::T1_MIN;

        if (yzz_reg[ttsp_pkg::P_T2])
            t2_sat = ttsp_pkg::T2_FLOOR;
        else if (t2_q > ttsp_pkg::T2_MAX)
            t2_sat = ttsp_pkg::T2_MAX;
        else if (t2_q <= ttsp_pkg::T2_FLOOR)
            t2_sat = ttsp_pkg::T2_FLOOR;
        else
            t2_sat = t2_q;
    end

    // Square-root lanes: norm of the whole vector, and 256 * r for the second tilt
    assign sq1[0].rad  = {16'd0, ss_reg};
    assign sq1[0].rem  = '0;
    assign sq1[0].root = '0;
    assign sq2[0].rad  = {yz_reg, 16'd0};
    assign sq2[0].rem  = '0;
    assign sq2[0].root = '0;

    // CORDIC chains
    assign c1[0] = c1_init_reg;

    assign c2[0].x   = $signed({2'b00, sq2[ttsp_pkg::SQRT_STEPS].root, 8'd0});
    assign c2[0].y   = $signed({10'd0, fxc_reg[ttsp_pkg::P_SQ_OUT], 8'd0});
    assign c2[0].acc = '0;

    genvar gi;
    generate
        for (gi = 0; gi < ttsp_pkg::SQRT_STEPS; gi++)
        begin : g_sqrt
            ttsp_sqrt_cell u_sq1
            (
                .clk  (clk),
                .en   (en),
                .din  (sq1[gi]),
                .dout (sq1[gi+1])
            );
            ttsp_sqrt_cell u_sq2
            (
                .clk  (clk),
                .en   (en),
                .din  (sq2[gi]),
                .dout (sq2[gi+1])
            );
        end
        for (gi = 0; gi < ttsp_pkg::CORDIC_STAGES; gi++)
        begin : g_cordic
            ttsp_cordic_cell u_c1
            (
                .clk      (clk),
                .en       (en),
                .step_idx (ttsp_pkg::STEP_W'(gi)),
                .din      (c1[gi]),
                .dout     (c1[gi+1])
            );
            ttsp_cordic_cell u_c2
            (
                .clk      (clk),
                .en       (en),
                .step_idx (ttsp_pkg::STEP_W'(gi)),
                .din      (c2[gi]),
                .dout     (c2[gi+1])
            );
        end
    endgenerate

    ttsp_angle_scale u_scale1
    (
        .clk   (clk),
        .en    (en),
        .acc   (post1_acc),
        .angle (t1_q)
    );

    ttsp_angle_scale u_scale2
    (
        .clk   (clk),
        .en    (en),
        .acc   (c2[ttsp_pkg::CORDIC_STAGES].acc),
        .angle (t2_q)
    );

    // Valid flags: advance with the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAT; k++)
                v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= s_axis_tvalid;
            for (int k = 1; k <= LAT; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    // Payload: advance with the chain, no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg[0] <= s_axis_tuser;
            fxc_reg[0] <= fxc_next;
            fy0_reg    <= $signed(s_axis_tdata[47:24]);
            fz0_reg    <= $signed(s_axis_tdata[71:48]);
            for (int k = 1; k <= LAT; k++)
                rot_reg[k] <= rot_reg[k-1];
            for (int k = 1; k <= ttsp_pkg::P_SQ_OUT; k++)
                fxc_reg[k] <= fxc_reg[k-1];

            fx2_reg     <= 48'(fxc_reg[0]) * 48'(fxc_reg[0]);
            fy2_reg     <= fy_sq;
            fz2_reg     <= fz_sq;
            c1_init_reg <= c1_init_next;
            z1_reg[1]   <= (fy0_reg == '0) && (fz0_reg == '0);
            for (int k = 2; k <= ttsp_pkg::P_C1_OUT; k++)
                z1_reg[k] <= z1_reg[k-1];

            yz_reg                    <= yz_next;
            ss_reg                    <= yz_next + fx2_reg;
            yzz_reg[ttsp_pkg::P_SQ_IN] <= (yz_next == '0);
            for (int k = ttsp_pkg::P_SQ_IN + 1; k <= ttsp_pkg::P_T2; k++)
                yzz_reg[k] <= yzz_reg[k-1];

            n_reg[ttsp_pkg::P_N] <= n_next;
            for (int k = ttsp_pkg::P_N + 1; k <= ttsp_pkg::P_T2; k++)
                n_reg[k] <= n_reg[k-1];

            t1_reg[ttsp_pkg::P_T1+1] <= t1_q;
            for (int k = ttsp_pkg::P_T1 + 2; k <= ttsp_pkg::P_T2; k++)
                t1_reg[k] <= t1_reg[k-1];

            speed_out_reg <= n_reg[ttsp_pkg::P_T2];
            t1_out_reg    <= t1_sat[ttsp_pkg::TILT1_W-1:0];
            t2_out_reg    <= t2_sat[ttsp_pkg::TILT2_W-1:0];
        end
    end

    assign m_axis_tvalid = v_reg[LAT];
    assign m_axis_tuser  = rot_reg[LAT];
    assign m_axis_tdata  = {4'd0, t2_out_reg, t1_out_reg, speed_out_reg};

endmodule
